[rtl/aapt_pkg.sv]
// shared types, constants and status codes of the aging address presence table
package aapt_pkg;

  // table geometry and field widths
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_W            = 48;
  localparam int LIFE_W            = 8;
  localparam int CNT_W             = 7;
  localparam int CNT_SAT           = 127;

  // configuration register
  localparam logic [LIFE_W-1:0] LIFE_TICKS_RESET = 8'd60;
  localparam logic              REG_LIFE_TICKS   = 1'b0;

  // item kinds
  localparam logic FUNC_SIGHT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_REFRESHED = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_DROPPED   = 2'd2;
  localparam logic [1:0] ST_TICK      = 2'd3;

  // input word
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } item_t;

  // output word
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] live_count;
  } result_t;

  // classified command handed from front to engine
  typedef struct packed {
    logic              is_tick;
    logic [ADDR_W-1:0] address;
  } cmd_t;

endpackage

[rtl/aging_address_presence_table.sv]
// Aging address presence table. Each item passes through the engine as a start,
// one table read per entry through the single registered read port of the
// address and life tables, an evaluation of the last entry and a write-back
// that loads the result register, which holds a finished word until it is
// taken; the write-back waits for that. A two-entry queue in front keeps
// accepting words while a command is scanned and it has room. life_ticks sits
// at byte address 0 of the APB-style port and reads back its value.
module aging_address_presence_table #(
  parameter int TABLE_ENTRIES = aapt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  aapt_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_ready,
  output aapt_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CNT_MAX_I = (TABLE_ENTRIES < aapt_pkg::CNT_SAT) ? TABLE_ENTRIES
                                                                  : aapt_pkg::CNT_SAT;
  localparam logic [aapt_pkg::CNT_W-1:0] CNT_MAX = aapt_pkg::CNT_W'(CNT_MAX_I);

  logic [aapt_pkg::LIFE_W-1:0] life_ticks;
  aapt_pkg::cmd_t              cmd;
  logic                        cmd_valid;
  logic                        cmd_pop;
  logic                        reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == aapt_pkg::REG_LIFE_TICKS);
  assign prdata  = reg_sel ? {24'd0, life_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      life_ticks <= aapt_pkg::LIFE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      life_ticks <= pwdata[aapt_pkg::LIFE_W-1:0];
    end
  end

  // front end queue
  aapt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop)
  );

  // table engine
  aapt_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .life_ticks   (life_ticks),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

`ifndef NO_ASSERTIONS
  // sightings never report a count
  a_count_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != aapt_pkg::ST_TICK |-> result.live_count == '0)
    else $error("live count on a sighting result");

  // live count bounded by the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.live_count <= CNT_MAX)
    else $error("live count above table size");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");
`endif

endmodule

[rtl/aapt_front.sv]
// front end: accepts input words, classifies them and queues commands
module aapt_front (
  input  logic           clk,
  input  logic           rst,
  input  aapt_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  output aapt_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_pop
);

  aapt_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  aapt_pkg::cmd_t cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.is_tick = (item.func == aapt_pkg::FUNC_TICK);
    cmd_in.address = item.address;
  end

  assign item_ready = (count != 2'd2);
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = slots[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_pop && cmd_valid;

  // two-entry queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd_in;
  end

endmodule

[rtl/aapt_engine.sv]
// back end: scans the address and life tables and produces one result per command
module aapt_engine #(
  parameter int TABLE_ENTRIES = aapt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [aapt_pkg::LIFE_W-1:0]   life_ticks,
  input  aapt_pkg::cmd_t                cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  output aapt_pkg::result_t             result,
  output logic                          result_valid,
  input  logic                          result_ready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [aapt_pkg::CNT_W-1:0] CNT_SAT = aapt_pkg::CNT_W'(aapt_pkg::CNT_SAT);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  // tables
  logic [aapt_pkg::ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
  logic [aapt_pkg::LIFE_W-1:0] life_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    written;

  state_t                      state;
  aapt_pkg::cmd_t              cur;
  logic [IDX_W-1:0]            rd_idx;
  logic                        rd_act;
  logic                        p_vld;
  logic [IDX_W-1:0]            p_idx;
  logic                        p_last;
  logic [aapt_pkg::ADDR_W-1:0] addr_q;
  logic [aapt_pkg::LIFE_W-1:0] life_q;
  logic                        wbit_q;
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx;
  logic                        have_free;
  logic [IDX_W-1:0]            free_idx;
  logic [aapt_pkg::CNT_W-1:0]  live_cnt;

  logic [aapt_pkg::LIFE_W-1:0] life_eff;
  logic [aapt_pkg::LIFE_W-1:0] life_dec;
  logic                        finish;
  logic                        lw_en;
  logic [IDX_W-1:0]            lw_idx;
  logic [aapt_pkg::LIFE_W-1:0] lw_data;
  logic                        aw_en;
  logic [aapt_pkg::LIFE_W-1:0] unused_life;

  // an entry never written since reset reads as a dead slot
  assign life_eff    = wbit_q ? life_q : '0;
  assign life_dec    = life_eff - aapt_pkg::LIFE_W'(1);
  assign finish      = (state == S_DONE) && (!result_valid || result_ready);
  assign cmd_pop     = (state == S_IDLE) && cmd_valid;
  assign unused_life = '0;

  // table write selection: decrement during a tick scan, load at sighting end
  always_comb begin
    lw_en   = 1'b0;
    lw_idx  = p_idx;
    lw_data = life_dec;
    aw_en   = 1'b0;
    if (state == S_SCAN && p_vld && cur.is_tick && life_eff != unused_life) begin
      lw_en = 1'b1;
    end else if (finish && !cur.is_tick) begin
      lw_data = life_ticks;
      if (hit) begin
        lw_en  = 1'b1;
        lw_idx = hit_idx;
      end else if (have_free) begin
        lw_en  = 1'b1;
        lw_idx = free_idx;
        aw_en  = 1'b1;
      end
    end
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    addr_q <= addr_mem[rd_idx];
    life_q <= life_mem[rd_idx];
  end

  // table write port
  always_ff @(posedge clk) begin
    if (lw_en) life_mem[lw_idx] <= lw_data;
    if (aw_en) addr_mem[lw_idx] <= cur.address;
  end

  // per-entry written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      wbit_q  <= 1'b0;
    end else begin
      wbit_q <= written[rd_idx];
      if (lw_en) written[lw_idx] <= 1'b1;
    end
  end

  // scan sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_act       <= 1'b0;
      p_vld        <= 1'b0;
      result_valid <= 1'b0;
      rd_idx       <= '0;
    end else begin
      // result register handshake
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          p_vld <= 1'b0;
          if (cmd_valid) begin
            cur       <= cmd;
            rd_idx    <= '0;
            rd_act    <= 1'b1;
            hit       <= 1'b0;
            have_free <= 1'b0;
            live_cnt  <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read per cycle
          p_vld  <= rd_act;
          p_idx  <= rd_idx;
          p_last <= (rd_idx == LAST_IDX);
          if (rd_act) begin
            if (rd_idx == LAST_IDX) rd_act <= 1'b0;
            else rd_idx <= rd_idx + IDX_W'(1);
          end
          // evaluate the entry read last cycle
          if (p_vld) begin
            if (cur.is_tick) begin
              if (life_eff != unused_life && life_dec != unused_life
                  && live_cnt < CNT_SAT) begin
                live_cnt <= live_cnt + aapt_pkg::CNT_W'(1);
              end
            end else if (life_eff == unused_life) begin
              have_free <= 1'b1;
              free_idx  <= p_idx;
            end else if (addr_q == cur.address && !hit) begin
              hit     <= 1'b1;
              hit_idx <= p_idx;
            end
            if (p_last) state <= S_DONE;
          end
        end
        S_DONE: begin
          p_vld <= 1'b0;
          if (finish) begin
            if (cur.is_tick) begin
              result.status     <= aapt_pkg::ST_TICK;
              result.live_count <= live_cnt;
            end else begin
              result.live_count <= '0;
              if (hit) result.status <= aapt_pkg::ST_REFRESHED;
              else if (have_free) result.status <= aapt_pkg::ST_INSERTED;
              else result.status <= aapt_pkg::ST_DROPPED;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/aging_address_presence_table_test.sv]
// testbench for the aging address presence table, random and directed words
module aging_address_presence_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = aapt_pkg::TABLE_ENTRIES_DEF;
  localparam logic [2:0] PADDR_LIFE_TICKS = {aapt_pkg::REG_LIFE_TICKS, 2'b00};
  // index 1 holds no register, writes there must be ignored
  localparam logic [2:0] PADDR_NO_REG = 3'd4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 100;
  localparam int POOL_SIZE = 160;

  // scoreboard: mirror of the table plus the queue of results still owed
  class presence_book;
    logic [aapt_pkg::ADDR_W-1:0] addr_tab [ENTRIES];
    logic [aapt_pkg::LIFE_W-1:0] life_tab [ENTRIES];
    logic [aapt_pkg::LIFE_W-1:0] life_ticks;
    aapt_pkg::result_t due_q [$];
    int fails;
    int checked;
    int status_seen [4];
    int top_live;

    function new();
      life_ticks = aapt_pkg::LIFE_TICKS_RESET;
      fails = 0;
      checked = 0;
      top_live = 0;
      foreach (life_tab[i]) begin
        life_tab[i] = '0;
        addr_tab[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fails++;
    endtask

    // apply one word to the mirrored table and return the result it owes
    function aapt_pkg::result_t age_step(aapt_pkg::item_t w);
      aapt_pkg::result_t r;
      logic have_free;
      int free_slot;
      int live;
      r.status = aapt_pkg::ST_TICK;
      r.live_count = '0;
      have_free = 1'b0;
      free_slot = 0;
      live = 0;
      // tick: age every live slot, count the survivors
      if (w.func == aapt_pkg::FUNC_TICK) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (life_tab[i] != '0) begin
            life_tab[i] = life_tab[i] - 1'b1;
            if (life_tab[i] != '0 && live < aapt_pkg::CNT_SAT) live++;
          end
        end
        r.live_count = aapt_pkg::CNT_W'(live);
        return r;
      end
      // sighting: refresh a live match, remember the highest free slot
      for (int i = 0; i < ENTRIES; i++) begin
        if (life_tab[i] == '0) begin
          have_free = 1'b1;
          free_slot = i;
        end else if (addr_tab[i] == w.address) begin
          life_tab[i] = life_ticks;
          r.status = aapt_pkg::ST_REFRESHED;
          return r;
        end
      end
      if (!have_free) begin
        r.status = aapt_pkg::ST_DROPPED;
      end else begin
        addr_tab[free_slot] = w.address;
        life_tab[free_slot] = life_ticks;
        r.status = aapt_pkg::ST_INSERTED;
      end
      return r;
    endfunction

    function void note(aapt_pkg::item_t w);
      due_q.push_back(age_step(w));
    endfunction

    task check(aapt_pkg::result_t got);
      aapt_pkg::result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected word status=%0d live_count=%0d",
                         got.status, got.live_count));
        return;
      end
      want = due_q.pop_front();
      checked++;
      status_seen[want.status]++;
      if (want.status == aapt_pkg::ST_TICK && int'(want.live_count) > top_live)
        top_live = int'(want.live_count);
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.live_count !== want.live_count)
        report($sformatf("live_count %0d, expected %0d", got.live_count, want.live_count));
    endtask
  endclass

  logic clk;
  logic rst;
  aapt_pkg::item_t item;
  logic item_valid;
  logic item_ready;
  aapt_pkg::result_t result;
  logic result_valid;
  logic result_ready;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  presence_book book;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [aapt_pkg::ADDR_W-1:0] pool [POOL_SIZE];

  // per phase: life_ticks (0 means pick at random), tick share, address window
  int phase_life [PHASES] = '{3, 1, 12, 0, 255, 200, 5, 7};
  int phase_tick_pct [PHASES] = '{25, 20, 15, 15, 4, 10, 30, 30};
  int phase_base [PHASES] = '{0, 40, 60, 90, 0, 0, 40, 100};
  int phase_span [PHASES] = '{40, 30, 70, 60, 90, 100, 60, 30};

  aging_address_presence_table dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, checking, and the watchdog
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (result_valid && result_ready) book.check(result);
      if ((result_valid && result_ready) || (item_valid && item_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("aging_address_presence_table_test NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [aapt_pkg::ADDR_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // offer one word after an optional gap and hold it until taken
  task automatic send_word(input logic func, input logic [aapt_pkg::ADDR_W-1:0] address);
    aapt_pkg::item_t w;
    w.func = func;
    w.address = address;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    book.note(w);
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    item_valid <= 1'b0;
    while (book.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == PADDR_LIFE_TICKS) book.life_ticks = data[aapt_pkg::LIFE_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // life_ticks must read back as last written
  task automatic read_back();
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_LIFE_TICKS;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== 32'(book.life_ticks))
      book.report($sformatf("life_ticks reads %0h, expected %0h", got, book.life_ticks));
    @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] addr, input logic [31:0] data);
    drain();
    apb_write(addr, data);
    read_back();
  endtask

  initial begin
    int pick;
    int life;
    book = new();
    rst <= 1'b1;
    item <= '0;
    item_valid <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // address pool, some entries one bit away from their neighbor
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 10 == 9)
        pool[i] = pool[i-1] ^ (48'd1 << $urandom_range(aapt_pkg::ADDR_W-1));
      else pool[i] = rand_addr();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, refresh, expiry, zero life, ignored index
    send_word(aapt_pkg::FUNC_SIGHT, '0);
    send_word(aapt_pkg::FUNC_SIGHT, '1);
    send_word(aapt_pkg::FUNC_SIGHT, '0);
    send_word(aapt_pkg::FUNC_SIGHT, 48'h5555_5555_5555);
    send_word(aapt_pkg::FUNC_SIGHT, 48'hAAAA_AAAA_AAAA);
    send_word(aapt_pkg::FUNC_TICK, '0);
    send_word(aapt_pkg::FUNC_TICK, '1);
    configure(PADDR_LIFE_TICKS, 32'd1);
    send_word(aapt_pkg::FUNC_SIGHT, '0);
    send_word(aapt_pkg::FUNC_TICK, '0);
    send_word(aapt_pkg::FUNC_SIGHT, '0);
    configure(PADDR_LIFE_TICKS, 32'd0);
    send_word(aapt_pkg::FUNC_SIGHT, '0);
    send_word(aapt_pkg::FUNC_SIGHT, 48'h1234_5678_9ABC);
    send_word(aapt_pkg::FUNC_TICK, '0);
    configure(PADDR_NO_REG, 32'd7);
    configure(PADDR_LIFE_TICKS, 32'hFFFF_FF00 | 32'd255);
    send_word(aapt_pkg::FUNC_SIGHT, '1);
    send_word(aapt_pkg::FUNC_TICK, 48'h0F0F_0F0F_0F0F);

    // random phases, each under its own life_ticks and pacing
    for (int ph = 0; ph < PHASES; ph++) begin
      life = (phase_life[ph] == 0) ? $urandom_range(254, 2) : phase_life[ph];
      configure(PADDR_LIFE_TICKS, {24'($urandom), 8'(life)});
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // sender holds off mid-phase until the table has answered everything
        if (ph == 3 && n == PHASE_WORDS / 2) drain();
        pick = $urandom_range(99);
        if (pick < phase_tick_pct[ph])
          send_word(aapt_pkg::FUNC_TICK, rand_addr());
        else if (pick < 92)
          send_word(aapt_pkg::FUNC_SIGHT,
                    pool[phase_base[ph] + $urandom_range(phase_span[ph] - 1)]);
        else
          send_word(aapt_pkg::FUNC_SIGHT, rand_addr());
      end
    end

    // wind down and let any stray word show up
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.due_q.size() != 0)
      book.report($sformatf("%0d results never arrived", book.due_q.size()));

    $display("checked %0d words: %0d refreshed, %0d inserted, %0d dropped, %0d ticks",
             book.checked, book.status_seen[aapt_pkg::ST_REFRESHED],
             book.status_seen[aapt_pkg::ST_INSERTED],
             book.status_seen[aapt_pkg::ST_DROPPED], book.status_seen[aapt_pkg::ST_TICK]);
    $display("life_ticks swept 0 to 255 over %0d paced phases, peak live count %0d",
             PHASES, book.top_live);
    if (book.fails == 0) begin
      $display("aging_address_presence_table_test OK");
    end else begin
      $display("aging_address_presence_table_test NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/aapt_pkg.sv
rtl/aapt_front.sv
rtl/aapt_engine.sv
rtl/aging_address_presence_table.sv
sim/aging_address_presence_table_test.sv
